FILE: sv/quad_grid_key_locator_assert.svh
`ifndef QUAD_GRID_KEY_LOCATOR_ASSERT_SVH
`define QUAD_GRID_KEY_LOCATOR_ASSERT_SVH

// implication checked in the same cycle
`define QGKL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define QGKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/qgkl_pkg.sv
package qgkl_pkg;

    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int COORD_W     = 19;
    localparam int DIFF_W      = 20;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CMP_W       = PROD_W + 2;
    localparam int IDX_W       = 3;
    localparam int KEY_W       = 8;
    localparam int RECIP_SHIFT = 16;

    localparam int DEF_GRID_COLUMNS = 4;
    localparam int DEF_GRID_ROWS    = 5;

    localparam int TABLE_COLS = 4;
    localparam int TABLE_ROWS = 5;
    localparam int TI_W       = $clog2(TABLE_COLS);
    localparam int TJ_W       = $clog2(TABLE_ROWS);

    localparam logic [KEY_W-1:0] KEY_TABLE [TABLE_COLS][TABLE_ROWS] = '{
        '{"N", "7", "4", "1", "0"},
        '{"/", "8", "5", "2", "0"},
        '{"*", "9", "6", "3", "."},
        '{"-", "+", "+", "E", "E"}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_LEFT_X,
        CFG_TOP_LEFT_Y,
        CFG_TOP_RIGHT_X,
        CFG_TOP_RIGHT_Y,
        CFG_BOTTOM_LEFT_X,
        CFG_BOTTOM_LEFT_Y,
        CFG_BOTTOM_RIGHT_X,
        CFG_BOTTOM_RIGHT_Y
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] top_left_x;
        logic [CFG_W-1:0] top_left_y;
        logic [CFG_W-1:0] top_right_x;
        logic [CFG_W-1:0] top_right_y;
        logic [CFG_W-1:0] bottom_left_x;
        logic [CFG_W-1:0] bottom_left_y;
        logic [CFG_W-1:0] bottom_right_x;
        logic [CFG_W-1:0] bottom_right_y;
    } corners_t;

    typedef struct packed {
        logic [DIFF_W-1:0] a;
        logic [DIFF_W-1:0] b;
    } mul_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_STEP_WB,
        ST_EDGE_N,
        ST_EDGE_P,
        ST_EDGE_CMP,
        ST_CELL_END,
        ST_DONE
    } state_t;

    function automatic logic signed [COORD_W-1:0] sext_cfg(input logic [CFG_W-1:0] v);
        return {{(COORD_W-CFG_W){v[CFG_W-1]}}, v};
    endfunction

endpackage

FILE: sv/qgkl_mul.sv
module qgkl_mul (
    input  logic                                clk,
    input  qgkl_pkg::mul_req_t                  req,
    output logic signed [qgkl_pkg::PROD_W-1:0]  prod
);

    logic signed [qgkl_pkg::DIFF_W-1:0] op_a;
    logic signed [qgkl_pkg::DIFF_W-1:0] op_b;
    logic signed [qgkl_pkg::PROD_W-1:0] prod_reg;

    assign op_a = req.a;
    assign op_b = req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= qgkl_pkg::PROD_W'(op_a) * qgkl_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: sv/qgkl_ctrl.sv
module qgkl_ctrl #(
    parameter int GRID_COLUMNS = qgkl_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS    = qgkl_pkg::DEF_GRID_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  qgkl_pkg::corners_t                  cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qgkl_pkg::CFG_W-1:0]   point_x,
    input  logic signed [qgkl_pkg::CFG_W-1:0]   point_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [qgkl_pkg::IDX_W-1:0]          cell_column,
    output logic [qgkl_pkg::IDX_W-1:0]          cell_row,
    output logic [qgkl_pkg::KEY_W-1:0]          key_code,
    output qgkl_pkg::mul_req_t                  mul_req,
    input  logic signed [qgkl_pkg::PROD_W-1:0]  mul_prod
);

    localparam int RECIP_ROWS =
        (2 ** qgkl_pkg::RECIP_SHIFT + GRID_ROWS - 1) / GRID_ROWS;
    localparam int RECIP_COLS =
        (2 ** qgkl_pkg::RECIP_SHIFT + GRID_COLUMNS - 1) / GRID_COLUMNS;
    localparam logic [qgkl_pkg::IDX_W-1:0] LAST_COL = qgkl_pkg::IDX_W'(GRID_COLUMNS - 1);
    localparam logic [qgkl_pkg::IDX_W-1:0] LAST_ROW = qgkl_pkg::IDX_W'(GRID_ROWS - 1);

    qgkl_pkg::state_t state_reg, state_next;
    logic [1:0]                       step_idx_reg, step_idx_next;
    logic [1:0]                       edge_reg, edge_next;
    logic                             inside_reg, inside_next;
    logic                             found_reg, found_next;
    logic [qgkl_pkg::IDX_W-1:0]       col_reg, col_next;
    logic [qgkl_pkg::IDX_W-1:0]       row_reg, row_next;
    logic                             out_valid_reg, out_valid_next;

    logic [qgkl_pkg::CFG_W-1:0]              px_reg, px_next;
    logic [qgkl_pkg::CFG_W-1:0]              py_reg, py_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     ldx_reg, ldx_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     ldy_reg, ldy_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     tdx_reg, tdx_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     tdy_reg, tdy_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     base_x_reg, base_x_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     base_y_reg, base_y_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     cur_x_reg, cur_x_next;
    logic signed [qgkl_pkg::COORD_W-1:0]     cur_y_reg, cur_y_next;
    logic signed [qgkl_pkg::DIFF_W-1:0]      a_reg, a_next;
    logic signed [qgkl_pkg::DIFF_W-1:0]      d_reg, d_next;
    logic signed [qgkl_pkg::PROD_W-1:0]      nprod_reg, nprod_next;
    logic                                    hit_reg, hit_next;
    logic [qgkl_pkg::IDX_W-1:0]              col_out_reg, col_out_next;
    logic [qgkl_pkg::IDX_W-1:0]              row_out_reg, row_out_next;
    logic [qgkl_pkg::KEY_W-1:0]              key_reg, key_next;

    // step division through the shared multiplier
    logic signed [qgkl_pkg::COORD_W-1:0] step_diff;
    logic signed [qgkl_pkg::COORD_W-1:0] step_mag;
    logic signed [qgkl_pkg::COORD_W-1:0] step_quot;
    logic signed [qgkl_pkg::COORD_W-1:0] step_val;
    logic signed [qgkl_pkg::DIFF_W-1:0]  step_recip;
    logic signed [qgkl_pkg::COORD_W-1:0] tl_x;
    logic signed [qgkl_pkg::COORD_W-1:0] tl_y;

    // current edge
    logic [1:0]                          edge_b;
    logic signed [qgkl_pkg::COORD_W-1:0] xa, ya, xb, yb;
    logic signed [qgkl_pkg::COORD_W-1:0] px_w, py_w;
    logic                                crosses;
    logic signed [qgkl_pkg::DIFF_W-1:0]  ax, ay, bx, dy;

    // crossing compare
    logic signed [qgkl_pkg::CMP_W-1:0] n_w, p_w, d_w, np, ap, dp;
    logic                              d_neg;
    logic                              toggle;

    // key lookup
    logic [qgkl_pkg::IDX_W-1:0] ti;
    logic [qgkl_pkg::IDX_W-1:0] tj;
    logic [qgkl_pkg::KEY_W-1:0] key_lookup;

    assign tl_x = qgkl_pkg::sext_cfg(cfg.top_left_x);
    assign tl_y = qgkl_pkg::sext_cfg(cfg.top_left_y);
    assign px_w = qgkl_pkg::sext_cfg(px_reg);
    assign py_w = qgkl_pkg::sext_cfg(py_reg);

    always_comb
    begin
        case (step_idx_reg)
            2'd0:    step_diff = qgkl_pkg::sext_cfg(cfg.bottom_left_x) - tl_x;
            2'd1:    step_diff = qgkl_pkg::sext_cfg(cfg.bottom_left_y) - tl_y;
            2'd2:    step_diff = qgkl_pkg::sext_cfg(cfg.top_right_x) - tl_x;
            default: step_diff = qgkl_pkg::sext_cfg(cfg.top_right_y) - tl_y;
        endcase
    end

    assign step_mag   = step_diff[qgkl_pkg::COORD_W-1] ? -step_diff : step_diff;
    assign step_recip = step_idx_reg[1] ? qgkl_pkg::DIFF_W'(RECIP_COLS)
                                        : qgkl_pkg::DIFF_W'(RECIP_ROWS);
    assign step_quot  = qgkl_pkg::COORD_W'(mul_prod[qgkl_pkg::RECIP_SHIFT +: qgkl_pkg::CFG_W]);
    assign step_val   = step_diff[qgkl_pkg::COORD_W-1] ? -step_quot : step_quot;

    // corners in order upper-left, upper-right, lower-right, lower-left
    assign edge_b = edge_reg + 2'd1;

    always_comb
    begin
        xa = cur_x_reg;
        ya = cur_y_reg;
        xb = cur_x_reg;
        yb = cur_y_reg;
        if ((edge_reg == 2'd1) || (edge_reg == 2'd2))
        begin
            xa = xa + tdx_reg;
            ya = ya + tdy_reg;
        end
        if ((edge_reg == 2'd2) || (edge_reg == 2'd3))
        begin
            xa = xa + ldx_reg;
            ya = ya + ldy_reg;
        end
        if ((edge_b == 2'd1) || (edge_b == 2'd2))
        begin
            xb = xb + tdx_reg;
            yb = yb + tdy_reg;
        end
        if ((edge_b == 2'd2) || (edge_b == 2'd3))
        begin
            xb = xb + ldx_reg;
            yb = yb + ldy_reg;
        end
    end

    assign crosses = (py_w <= ya) != (py_w <= yb);
    assign ax = qgkl_pkg::DIFF_W'(px_w) - qgkl_pkg::DIFF_W'(xa);
    assign ay = qgkl_pkg::DIFF_W'(py_w) - qgkl_pkg::DIFF_W'(ya);
    assign bx = qgkl_pkg::DIFF_W'(xb) - qgkl_pkg::DIFF_W'(xa);
    assign dy = qgkl_pkg::DIFF_W'(yb) - qgkl_pkg::DIFF_W'(ya);

    // a < trunc(n / d) without a divider: normalize d positive, then
    // n >= 0: (a + 1) * d <= n, n < 0: a * d < n
    assign n_w   = qgkl_pkg::CMP_W'(nprod_reg);
    assign p_w   = qgkl_pkg::CMP_W'(mul_prod);
    assign d_w   = qgkl_pkg::CMP_W'(d_reg);
    assign d_neg = d_reg[qgkl_pkg::DIFF_W-1];
    assign np    = d_neg ? -n_w : n_w;
    assign ap    = d_neg ? -p_w : p_w;
    assign dp    = d_neg ? -d_w : d_w;
    assign toggle = np[qgkl_pkg::CMP_W-1] ? (ap < np) : ((ap + dp) <= np);

    assign ti = LAST_COL - col_reg;
    assign tj = LAST_ROW - row_reg;

    always_comb
    begin
        key_lookup = '0;
        if ((ti < qgkl_pkg::IDX_W'(qgkl_pkg::TABLE_COLS)) &&
            (tj < qgkl_pkg::IDX_W'(qgkl_pkg::TABLE_ROWS)))
        begin
            key_lookup = qgkl_pkg::KEY_TABLE[ti[qgkl_pkg::TI_W-1:0]][tj[qgkl_pkg::TJ_W-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_idx_next  = step_idx_reg;
        edge_next      = edge_reg;
        inside_next    = inside_reg;
        found_next     = found_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        px_next        = px_reg;
        py_next        = py_reg;
        ldx_next       = ldx_reg;
        ldy_next       = ldy_reg;
        tdx_next       = tdx_reg;
        tdy_next       = tdy_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        nprod_next     = nprod_reg;
        hit_next       = hit_reg;
        col_out_next   = col_out_reg;
        row_out_next   = row_out_reg;
        key_next       = key_reg;
        mul_req        = '0;

        case (state_reg)
            qgkl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    px_next       = point_x;
                    py_next       = point_y;
                    step_idx_next = 2'd0;
                    found_next    = 1'b0;
                    state_next    = qgkl_pkg::ST_STEP;
                end
            end

            qgkl_pkg::ST_STEP:
            begin
                mul_req.a  = qgkl_pkg::DIFF_W'(step_mag);
                mul_req.b  = step_recip;
                state_next = qgkl_pkg::ST_STEP_WB;
            end

            qgkl_pkg::ST_STEP_WB:
            begin
                case (step_idx_reg)
                    2'd0:    ldx_next = step_val;
                    2'd1:    ldy_next = step_val;
                    2'd2:    tdx_next = step_val;
                    default: tdy_next = step_val;
                endcase
                if (step_idx_reg == 2'd3)
                begin
                    col_next    = '0;
                    row_next    = '0;
                    base_x_next = tl_x;
                    base_y_next = tl_y;
                    cur_x_next  = tl_x;
                    cur_y_next  = tl_y;
                    edge_next   = 2'd0;
                    inside_next = 1'b0;
                    state_next  = qgkl_pkg::ST_EDGE_N;
                end
                else
                begin
                    step_idx_next = step_idx_reg + 2'd1;
                    state_next    = qgkl_pkg::ST_STEP;
                end
            end

            qgkl_pkg::ST_EDGE_N:
            begin
                if (crosses)
                begin
                    mul_req.a  = ay;
                    mul_req.b  = bx;
                    a_next     = ax;
                    d_next     = dy;
                    state_next = qgkl_pkg::ST_EDGE_P;
                end
                else if (edge_reg == 2'd3)
                begin
                    state_next = qgkl_pkg::ST_CELL_END;
                end
                else
                begin
                    edge_next = edge_b;
                end
            end

            qgkl_pkg::ST_EDGE_P:
            begin
                nprod_next = mul_prod;
                mul_req.a  = a_reg;
                mul_req.b  = d_reg;
                state_next = qgkl_pkg::ST_EDGE_CMP;
            end

            qgkl_pkg::ST_EDGE_CMP:
            begin
                inside_next = inside_reg ^ toggle;
                if (edge_reg == 2'd3)
                begin
                    state_next = qgkl_pkg::ST_CELL_END;
                end
                else
                begin
                    edge_next  = edge_b;
                    state_next = qgkl_pkg::ST_EDGE_N;
                end
            end

            qgkl_pkg::ST_CELL_END:
            begin
                edge_next   = 2'd0;
                inside_next = 1'b0;
                state_next  = qgkl_pkg::ST_EDGE_N;
                if (inside_reg)
                begin
                    found_next = 1'b1;
                    state_next = qgkl_pkg::ST_DONE;
                end
                else if (row_reg == LAST_ROW)
                begin
                    if (col_reg == LAST_COL)
                    begin
                        state_next = qgkl_pkg::ST_DONE;
                    end
                    else
                    begin
                        col_next    = col_reg + 1'b1;
                        row_next    = '0;
                        base_x_next = base_x_reg + tdx_reg;
                        base_y_next = base_y_reg + tdy_reg;
                        cur_x_next  = base_x_reg + tdx_reg;
                        cur_y_next  = base_y_reg + tdy_reg;
                    end
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    cur_x_next = cur_x_reg + ldx_reg;
                    cur_y_next = cur_y_reg + ldy_reg;
                end
            end

            qgkl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = found_reg;
                    col_out_next   = found_reg ? col_reg : '0;
                    row_out_next   = found_reg ? row_reg : '0;
                    key_next       = found_reg ? key_lookup : '0;
                    state_next     = qgkl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = qgkl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qgkl_pkg::ST_IDLE;
            step_idx_reg  <= '0;
            edge_reg      <= '0;
            inside_reg    <= 1'b0;
            found_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_idx_reg  <= step_idx_next;
            edge_reg      <= edge_next;
            inside_reg    <= inside_next;
            found_reg     <= found_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        ldx_reg     <= ldx_next;
        ldy_reg     <= ldy_next;
        tdx_reg     <= tdx_next;
        tdy_reg     <= tdy_next;
        base_x_reg  <= base_x_next;
        base_y_reg  <= base_y_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        a_reg       <= a_next;
        d_reg       <= d_next;
        nprod_reg   <= nprod_next;
        hit_reg     <= hit_next;
        col_out_reg <= col_out_next;
        row_out_reg <= row_out_next;
        key_reg     <= key_next;
    end

    assign in_ready    = (state_reg == qgkl_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign cell_column = col_out_reg;
    assign cell_row    = row_out_reg;
    assign key_code    = key_reg;

endmodule

FILE: sv/quad_grid_key_locator.sv
// each click first runs the step setup, then tests cells in turn until a hit or the
// last cell, using the shared 20x20 multiplier: one product per step division and
// two per crossing edge
// throughput: one click at a time; the next is taken the cycle after the result is
// registered, which waits only while an earlier result beat is still unclaimed
// reset: control state and all eight corner registers clear to zero
module quad_grid_key_locator #(
    parameter int GRID_COLUMNS = qgkl_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS    = qgkl_pkg::DEF_GRID_ROWS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qgkl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [qgkl_pkg::CFG_W-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [qgkl_pkg::CFG_W-1:0]     point_x,
    input  logic signed [qgkl_pkg::CFG_W-1:0]     point_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic [qgkl_pkg::IDX_W-1:0]            cell_column,
    output logic [qgkl_pkg::IDX_W-1:0]            cell_row,
    output logic [qgkl_pkg::KEY_W-1:0]            key_code
);

    qgkl_pkg::corners_t                 cfg_reg, cfg_next;
    qgkl_pkg::mul_req_t                 mul_req;
    logic signed [qgkl_pkg::PROD_W-1:0] mul_prod;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (qgkl_pkg::cfg_reg_t'(cfg_index))
                qgkl_pkg::CFG_TOP_LEFT_X:     cfg_next.top_left_x     = cfg_data;
                qgkl_pkg::CFG_TOP_LEFT_Y:     cfg_next.top_left_y     = cfg_data;
                qgkl_pkg::CFG_TOP_RIGHT_X:    cfg_next.top_right_x    = cfg_data;
                qgkl_pkg::CFG_TOP_RIGHT_Y:    cfg_next.top_right_y    = cfg_data;
                qgkl_pkg::CFG_BOTTOM_LEFT_X:  cfg_next.bottom_left_x  = cfg_data;
                qgkl_pkg::CFG_BOTTOM_LEFT_Y:  cfg_next.bottom_left_y  = cfg_data;
                qgkl_pkg::CFG_BOTTOM_RIGHT_X: cfg_next.bottom_right_x = cfg_data;
                qgkl_pkg::CFG_BOTTOM_RIGHT_Y: cfg_next.bottom_right_y = cfg_data;
                default:                      cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    qgkl_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    qgkl_ctrl #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .key_code    (key_code),
        .mul_req     (mul_req),
        .mul_prod    (mul_prod)
    );

endmodule

FILE: sv/qgkl_checker.sv
`include "quad_grid_key_locator_assert.svh"

module qgkl_checker #(
    parameter int GRID_COLUMNS = qgkl_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS    = qgkl_pkg::DEF_GRID_ROWS
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [qgkl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [qgkl_pkg::CFG_W-1:0]        cfg_data,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [qgkl_pkg::CFG_W-1:0]        point_x,
    input logic [qgkl_pkg::CFG_W-1:0]        point_y,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              hit,
    input logic [qgkl_pkg::IDX_W-1:0]        cell_column,
    input logic [qgkl_pkg::IDX_W-1:0]        cell_row,
    input logic [qgkl_pkg::KEY_W-1:0]        key_code
);

    localparam logic [qgkl_pkg::IDX_W-1:0] LAST_COL = qgkl_pkg::IDX_W'(GRID_COLUMNS - 1);
    localparam logic [qgkl_pkg::IDX_W-1:0] LAST_ROW = qgkl_pkg::IDX_W'(GRID_ROWS - 1);

    logic [qgkl_pkg::CFG_IDX_W-1:0] cfg_index_seen;
    logic [qgkl_pkg::CFG_W-1:0]     cfg_data_seen;
    logic [qgkl_pkg::CFG_W-1:0]     point_x_seen;
    logic [qgkl_pkg::CFG_W-1:0]     point_y_seen;

    assign cfg_index_seen = cfg_index;
    assign cfg_data_seen  = cfg_data;
    assign point_x_seen   = point_x;
    assign point_y_seen   = point_y;

    // a taken click drops in_ready, as the block is then busy with the step setup
    `QGKL_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready && !cfg_valid || !in_ready, "input accepted while busy")

    `QGKL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(cell_column) && $stable(cell_row) && $stable(key_code), "result beat changed while stalled")

    `QGKL_ASSERT_SAME(a_miss_zero, out_valid && !hit, (cell_column == '0) && (cell_row == '0) && (key_code == '0), "miss with nonzero fields")

    `QGKL_ASSERT_SAME(a_hit_in_grid, out_valid && hit, (cell_column <= LAST_COL) && (cell_row <= LAST_ROW), "hit outside grid")

    `QGKL_ASSERT_SAME(a_cfg_always_ready, cfg_valid && (cfg_index_seen == cfg_index_seen) && (cfg_data_seen == cfg_data_seen) && (point_x_seen == point_x_seen) && (point_y_seen == point_y_seen), cfg_ready, "config write refused")

endmodule

bind quad_grid_key_locator qgkl_checker #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
) u_qgkl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .key_code    (key_code)
);

FILE: test/tb_quad_grid_key_locator.sv
`timescale 1ns / 1ps

module tb_quad_grid_key_locator;

    import qgkl_pkg::*;

    localparam int GRID_COLS     = 4;
    localparam int GRID_ROWS     = 5;
    localparam int TAIL_ITEMS    = 150;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 300;
    localparam int MAX_REPORTS   = 100;
    localparam longint LIMIT_NS  = 30_000_000;

    localparam logic [7:0] KEYPAD [4][5] = '{
        '{"N", "7", "4", "1", "0"},
        '{"/", "8", "5", "2", "0"},
        '{"*", "9", "6", "3", "."},
        '{"-", "+", "+", "E", "E"}
    };

    typedef struct packed {
        logic                    is_cfg;
        cfg_reg_t                reg_sel;
        logic signed [CFG_W-1:0] data;
        logic signed [CFG_W-1:0] px;
        logic signed [CFG_W-1:0] py;
        logic [6:0]              idle_pct;
    } click_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
        logic [KEY_W-1:0] key;
    } key_hit_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic signed [CFG_W-1:0] cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [CFG_W-1:0] point_x = '0;
    logic signed [CFG_W-1:0] point_y = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    hit;
    logic [IDX_W-1:0]        cell_column;
    logic [IDX_W-1:0]        cell_row;
    logic [KEY_W-1:0]        key_code;

    click_t   click_q [$];
    key_hit_t key_hits_q [$];
    longint   corner_reg [8];
    longint   plan_corner [8];
    int       mismatch_cnt = 0;
    int       gap_cnt = 0;
    int       stall_cnt = 0;
    int       quiet_cnt = 0;
    int       idle_pct = 0;

    quad_grid_key_locator #(
        .GRID_COLUMNS (GRID_COLS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .key_code    (key_code)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // crossing test for one polygon edge
    function automatic bit edge_crosses(input longint px, input longint py,
                                        input longint xa, input longint ya,
                                        input longint xb, input longint yb);
        longint dy;
        dy = yb - ya;
        if ((py <= ya) == (py <= yb) || dy == 0)
            return 1'b0;
        return (px - xa) < ((py - ya) * (xb - xa)) / dy;
    endfunction

    function automatic key_hit_t locate_key(input longint px, input longint py);
        longint   tlx, tly, tdx, tdy, ldx, ldy;
        longint   vx [4];
        longint   vy [4];
        bit       in_cell;
        int       ti, tj;
        key_hit_t res;
        res = '0;
        tlx = corner_reg[CFG_TOP_LEFT_X];
        tly = corner_reg[CFG_TOP_LEFT_Y];
        ldy = (corner_reg[CFG_BOTTOM_LEFT_Y] - tly) / GRID_ROWS;
        ldx = (corner_reg[CFG_BOTTOM_LEFT_X] - tlx) / GRID_ROWS;
        tdx = (corner_reg[CFG_TOP_RIGHT_X] - tlx) / GRID_COLS;
        tdy = (corner_reg[CFG_TOP_RIGHT_Y] - tly) / GRID_COLS;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                vx[0] = r * ldx + c * tdx + tlx;
                vy[0] = r * ldy + c * tdy + tly;
                vx[1] = r * ldx + (c + 1) * tdx + tlx;
                vy[1] = r * ldy + (c + 1) * tdy + tly;
                vx[2] = (r + 1) * ldx + (c + 1) * tdx + tlx;
                vy[2] = (r + 1) * ldy + (c + 1) * tdy + tly;
                vx[3] = (r + 1) * ldx + c * tdx + tlx;
                vy[3] = (r + 1) * ldy + c * tdy + tly;
                in_cell = 1'b0;
                for (int e = 0; e < 4; e++)
                begin
                    if (edge_crosses(px, py, vx[e], vy[e], vx[(e + 1) % 4], vy[(e + 1) % 4]))
                        in_cell = !in_cell;
                end
                if (in_cell)
                begin
                    ti = GRID_COLS - 1 - c;
                    tj = GRID_ROWS - 1 - r;
                    res.hit    = 1'b1;
                    res.column = c[IDX_W-1:0];
                    res.row    = r[IDX_W-1:0];
                    if (ti >= 0 && ti < 4 && tj >= 0 && tj < 5)
                        res.key = KEYPAD[ti][tj];
                    return res;
                end
            end
        end
        return res;
    endfunction

    function automatic int rnd_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int clamp12(input longint v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return int'(v);
    endfunction

    task automatic push_write(input cfg_reg_t sel, input int value);
        click_t s;
        s.is_cfg   = 1'b1;
        s.reg_sel  = sel;
        s.data     = value[CFG_W-1:0];
        s.px       = '0;
        s.py       = '0;
        s.idle_pct = '0;
        click_q.push_back(s);
        plan_corner[sel] = value;
    endtask

    task automatic queue_corners(input int tlx, input int tly, input int trx, input int tr_y,
                                 input int blx, input int bly, input int brx, input int bry);
        push_write(CFG_TOP_LEFT_X, tlx);
        push_write(CFG_TOP_LEFT_Y, tly);
        push_write(CFG_TOP_RIGHT_X, trx);
        push_write(CFG_TOP_RIGHT_Y, tr_y);
        push_write(CFG_BOTTOM_LEFT_X, blx);
        push_write(CFG_BOTTOM_LEFT_Y, bly);
        push_write(CFG_BOTTOM_RIGHT_X, brx);
        push_write(CFG_BOTTOM_RIGHT_Y, bry);
    endtask

    task automatic push_point(input int x, input int y, input int idle);
        click_t s;
        s.is_cfg   = 1'b0;
        s.reg_sel  = CFG_TOP_LEFT_X;
        s.data     = '0;
        s.px       = x[CFG_W-1:0];
        s.py       = y[CFG_W-1:0];
        s.idle_pct = idle[6:0];
        click_q.push_back(s);
    endtask

    // mostly points spread over the planned grid, some anywhere
    task automatic queue_points(input int n, input int idle);
        longint tlx, tly, tdx, tdy, ldx, ldy, px, py;
        int     c, r, u, v;
        tlx = plan_corner[CFG_TOP_LEFT_X];
        tly = plan_corner[CFG_TOP_LEFT_Y];
        tdx = (plan_corner[CFG_TOP_RIGHT_X] - tlx) / GRID_COLS;
        tdy = (plan_corner[CFG_TOP_RIGHT_Y] - tly) / GRID_COLS;
        ldx = (plan_corner[CFG_BOTTOM_LEFT_X] - tlx) / GRID_ROWS;
        ldy = (plan_corner[CFG_BOTTOM_LEFT_Y] - tly) / GRID_ROWS;
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                px = rnd_coord();
                py = rnd_coord();
            end
            else
            begin
                c = $urandom_range(0, GRID_COLS - 1);
                r = $urandom_range(0, GRID_ROWS - 1);
                u = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 99);
                v = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 99);
                px = tlx + c * tdx + r * ldx + (u * tdx + v * ldx) / 100;
                py = tly + c * tdy + r * ldy + (u * tdy + v * ldy) / 100;
            end
            push_point(clamp12(px), clamp12(py), idle);
        end
    endtask

    task automatic queue_keyboard();
        int w, h, tlx, tly;
        w   = $urandom_range(40, 1800);
        h   = $urandom_range(40, 1800);
        tlx = int'($urandom_range(0, 3800 - w)) - 1900;
        tly = int'($urandom_range(0, 3800 - h)) - 1900;
        queue_corners(tlx, tly,
                      tlx + w, tly + int'($urandom_range(0, 200)) - 100,
                      tlx + int'($urandom_range(0, 200)) - 100, tly + h,
                      tlx + w + int'($urandom_range(0, 200)) - 100,
                      tly + h + int'($urandom_range(0, 200)) - 100);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        click_t cur;
        logic   nxt_in_v;
        logic   nxt_cfg_v;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            out_ready <= 1'b0;
            gap_cnt   = 0;
            stall_cnt = 0;
            quiet_cnt = 0;
        end
        else
        begin
            nxt_in_v  = in_valid && !in_ready;
            nxt_cfg_v = cfg_valid && !cfg_ready;
            if ((in_valid && in_ready) || (cfg_valid && cfg_ready))
            begin
                if (click_q.size() >= TAIL_ITEMS && $urandom_range(0, 99) < idle_pct)
                    gap_cnt = $urandom_range(1, 7);
            end
            if (key_hits_q.size() == 0 && !in_valid && !out_valid)
                quiet_cnt = (quiet_cnt < DRAIN_CYCLES) ? quiet_cnt + 1 : quiet_cnt;
            else
                quiet_cnt = 0;
            if (!nxt_in_v && !nxt_cfg_v)
            begin
                if (gap_cnt > 0)
                    gap_cnt--;
                else if (click_q.size() > 0)
                begin
                    if (!click_q[0].is_cfg)
                    begin
                        cur      = click_q.pop_front();
                        idle_pct = cur.idle_pct;
                        nxt_in_v = 1'b1;
                        point_x  <= cur.px;
                        point_y  <= cur.py;
                    end
                    else if (quiet_cnt >= DRAIN_CYCLES)
                    begin
                        cur       = click_q.pop_front();
                        nxt_cfg_v = 1'b1;
                        cfg_index <= cur.reg_sel;
                        cfg_data  <= cur.data;
                    end
                end
            end
            in_valid  <= nxt_in_v;
            cfg_valid <= nxt_cfg_v;

            // result side back-pressure
            if (stall_cnt == 0 && click_q.size() >= TAIL_ITEMS
                && $urandom_range(0, 99) < idle_pct)
                stall_cnt = $urandom_range(1, 7);
            out_ready <= (stall_cnt == 0);
            if (stall_cnt > 0)
                stall_cnt--;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        key_hit_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                corner_reg[i] = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                corner_reg[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                key_hits_q.push_back(locate_key(point_x, point_y));
            if (out_valid && out_ready)
            begin
                if (key_hits_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t ns: result beat with nothing expected, actual hit %0d key %0d",
                             $time, hit, key_code);
                end
                else
                begin
                    want = key_hits_q.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", want.hit, hit);
                    if (cell_column !== want.column)
                        report_mismatch("cell_column", want.column, cell_column);
                    if (cell_row !== want.row)
                        report_mismatch("cell_row", want.row, cell_row);
                    if (key_code !== want.key)
                        report_mismatch("key_code", want.key, key_code);
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            plan_corner[i] = 0;

        // registers still at reset
        queue_points(8, 30);

        // upright grid: every key center, far corners, one vertex
        queue_corners(-400, -300, 400, -300, -400, 300, 400, 300);
        for (int c = 0; c < GRID_COLS; c++)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                push_point(-300 + c * 200, -240 + r * 120, 30);
        end
        push_point(-2048, -2048, 30);
        push_point(2047, 2047, 30);
        push_point(-2048, 2047, 30);
        push_point(2047, -2048, 30);
        push_point(-400, -300, 30);

        // full range, then mirrored so the nonzero steps go negative
        queue_corners(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047);
        queue_points(120, 30);
        queue_corners(2047, 2047, -2048, 2047, 2047, -2048, -2048, -2048);
        queue_points(120, 70);

        for (int k = 0; k < 12; k++)
        begin
            if (k % 2 == 0)
                queue_keyboard();
            else
                queue_corners(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                              rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            queue_points(120, (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 30 : 70));
        end

        // collapsed quadrilaterals
        queue_corners(100, 100, 100, 100, 100, 100, 100, 100);
        queue_points(20, 30);
        queue_corners(-500, 0, 500, 0, -500, 0, 500, 0);
        queue_points(20, 30);

        queue_keyboard();
        queue_points(TAIL_ITEMS, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (click_q.size() != 0 || in_valid || cfg_valid || key_hits_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && key_hits_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
